// ===== rtl/hbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Heap block census package
// Sizes, result codes and the command bundle shared by the census cells.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int SIZE_SLOTS = 16;
    localparam int TOP_HOLES  = 8;
    localparam int SIZE_W     = 32;
    localparam int KIND_W     = 2;
    localparam int SLOT_IDX_W = 4;

    // Number of items in one census dump: every slot, the summary, every hole.
    localparam int CENSUS_LEN = SIZE_SLOTS + 1 + TOP_HOLES;
    localparam int IDX_W      = $clog2(CENSUS_LEN);

    localparam logic [SIZE_W-1:0] THRESHOLD_RESET = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] SIZE_MAX        = '1;

    localparam logic [KIND_W-1:0] KIND_SLOT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOLE  = 2'd2;

    // Command broadcast to every cell of one chain.
    typedef struct packed {
        logic              step;   // apply the held block to the chain
        logic              shift;  // move every entry one place towards cell 0
        logic [SIZE_W-1:0] size;   // size of the held block
    } t_cell_cmd;

endpackage

// ===== rtl/hbc_slot_cell.sv =====
// ----------------------------------------------------------------------------
// Heap block census: size slot cell
// Holds one distinct used size and its saturating block count.
// ----------------------------------------------------------------------------
module hbc_slot_cell import hbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic              i_prev_valid,
    input  logic              i_hit_in,
    input  logic [SIZE_W-1:0] i_next_size,
    input  logic [SIZE_W-1:0] i_next_count,
    output logic              o_valid,
    output logic              o_hit_out,
    output logic [SIZE_W-1:0] o_size,
    output logic [SIZE_W-1:0] o_count
);

    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_count, n_count;
    logic              hit;
    logic              take;

    assign o_valid   = (r_count != '0);
    assign hit       = o_valid && (r_size == i_cmd.size);
    // Filled slots form a prefix, so the first empty cell sits right after a
    // filled one and only sees hits from cells before it.
    assign take      = !o_valid && i_prev_valid && !i_hit_in;
    assign o_hit_out = i_hit_in | hit;
    assign o_size    = r_size;
    assign o_count   = r_count;

    always_comb begin
        n_size  = r_size;
        n_count = r_count;
        priority if (i_cmd.shift) begin
            n_size  = i_next_size;
            n_count = i_next_count;
        end else if (i_cmd.step && hit) begin
            n_count = (r_count == SIZE_MAX) ? SIZE_MAX : r_count + SIZE_W'(1);
        end else if (i_cmd.step && take) begin
            n_size  = i_cmd.size;
            n_count = SIZE_W'(1);
        end else begin
            n_size  = r_size;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_count <= '0;
        end else begin
            r_size  <= n_size;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/hbc_hole_cell.sv =====
// ----------------------------------------------------------------------------
// Heap block census: hole rank cell
// Holds one rank of the descending list of the largest free blocks.
// ----------------------------------------------------------------------------
module hbc_hole_cell import hbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic              i_prev_gt,
    input  logic [SIZE_W-1:0] i_prev_size,
    input  logic [SIZE_W-1:0] i_next_size,
    output logic              o_gt,
    output logic [SIZE_W-1:0] o_size
);

    logic [SIZE_W-1:0] r_size, n_size;

    // Strictly larger only: an equal hole ranks below the existing one.
    assign o_gt   = (i_cmd.size > r_size);
    assign o_size = r_size;

    always_comb begin
        n_size = r_size;
        priority if (i_cmd.shift) begin
            n_size = i_next_size;
        end else if (i_cmd.step && o_gt) begin
            // Either the insertion point or a cell that makes room below it.
            n_size = i_prev_gt ? i_prev_size : i_cmd.size;
        end else begin
            n_size = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else begin
            r_size <= n_size;
        end
    end

endmodule

// ===== rtl/heap_block_census.sv =====
// ----------------------------------------------------------------------------
// Heap block census
// Counts used blocks by distinct size, totals small ones, ranks free holes
// and dumps the whole census at the end of each heap walk.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ------------------------------
//  in        input      i_in_valid / o_in_ready     block_size, block_used, walk_end
//  out       output     o_out_valid / i_out_ready   result_kind, slot_index,
//                                                   size_value, count_value,
//                                                   last_result
//  cfg       input      i_cfg_we (no wait)          small_threshold
//
// Each item is first captured; then both cell chains compare against it and
// update in parallel before the next item is taken. At the end of a walk the
// census of 25 items is unloaded one per accepted output, by shifting the
// chains towards their first cell, which also clears them. Reset is
// synchronous and active low; it empties the census and restores the
// threshold to 512. A stalled output simply holds the dump in place.
// ----------------------------------------------------------------------------
module heap_block_census import hbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [SIZE_W-1:0]     i_cfg_data,
    // Input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SIZE_W-1:0]     i_block_size,
    input  logic                  i_block_used,
    input  logic                  i_walk_end,
    // Result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [KIND_W-1:0]     o_result_kind,
    output logic [SLOT_IDX_W-1:0] o_slot_index,
    output logic [SIZE_W-1:0]     o_size_value,
    output logic [SIZE_W-1:0]     o_count_value,
    output logic                  o_last_result
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
    localparam logic [1:0] ST_STEP = 2'd1;  // chains update with the held item
    localparam logic [1:0] ST_DUMP = 2'd2;  // census being unloaded

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [SIZE_W-1:0] r_thr;

    // Held item; payload only, so no reset is needed.
    logic [SIZE_W-1:0] r_size;
    logic              r_used;
    logic              r_end;

    logic [SIZE_W-1:0] r_other_count, n_other_count;
    logic [SIZE_W-1:0] r_other_bytes, n_other_bytes;

    logic              in_fire;
    logic              out_fire;
    logic              thr_ok;
    logic              to_other;
    logic [SIZE_W:0]   bytes_sum;

    logic              dump_slot;
    logic              dump_other;
    logic              dump_hole;
    logic [IDX_W-1:0]  hole_rank;

    t_cell_cmd         slot_cmd;
    t_cell_cmd         hole_cmd;

    logic [SIZE_W-1:0]     slot_size   [SIZE_SLOTS];
    logic [SIZE_W-1:0]     slot_count  [SIZE_SLOTS];
    logic [SIZE_SLOTS-1:0] slot_valid;
    logic [SIZE_SLOTS:0]   slot_hit;

    logic [SIZE_W-1:0]     hole_size   [TOP_HOLES];
    logic [TOP_HOLES-1:0]  hole_gt;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_DUMP);

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // Capture the item while idle.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_size <= i_block_size;
            r_used <= i_block_used;
            r_end  <= i_walk_end;
        end
    end

    // ------------------------------------------------------------------
    // Dump position decoding: slots first, then the summary, then holes.
    // ------------------------------------------------------------------
    assign dump_slot  = (r_idx < IDX_W'(SIZE_SLOTS));
    assign dump_other = (r_idx == IDX_W'(SIZE_SLOTS));
    assign dump_hole  = !dump_slot && !dump_other;
    assign hole_rank  = r_idx - IDX_W'(SIZE_SLOTS + 1);

    // ------------------------------------------------------------------
    // Size slot chain. The hit flag ripples from cell 0 so that the first
    // empty cell knows whether the size is already present.
    // ------------------------------------------------------------------
    assign thr_ok = (r_size >= r_thr);

    always_comb begin
        slot_cmd.step  = (r_state == ST_STEP) && r_used && thr_ok;
        slot_cmd.shift = out_fire && dump_slot;
        slot_cmd.size  = r_size;
    end

    assign slot_hit[0] = 1'b0;

    for (genvar g = 0; g < SIZE_SLOTS; g++) begin : g_slot
        logic              prev_valid;
        logic [SIZE_W-1:0] next_size;
        logic [SIZE_W-1:0] next_count;

        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = slot_valid[g-1];
        end

        if (g == SIZE_SLOTS - 1) begin : g_last
            assign next_size  = '0;
            assign next_count = '0;
        end else begin : g_inner
            assign next_size  = slot_size[g+1];
            assign next_count = slot_count[g+1];
        end

        hbc_slot_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (slot_cmd),
            .i_prev_valid (prev_valid),
            .i_hit_in     (slot_hit[g]),
            .i_next_size  (next_size),
            .i_next_count (next_count),
            .o_valid      (slot_valid[g]),
            .o_hit_out    (slot_hit[g+1]),
            .o_size       (slot_size[g]),
            .o_count      (slot_count[g])
        );
    end

    // A used block goes to the summary when it is small, or when it neither
    // matched a slot nor found an empty one (the table is full).
    assign to_other = !thr_ok || (!slot_hit[SIZE_SLOTS] && slot_valid[SIZE_SLOTS-1]);

    // ------------------------------------------------------------------
    // Hole chain: each cell compares, and takes either the new size or the
    // size of its left neighbour when the insertion point lies above it.
    // ------------------------------------------------------------------
    always_comb begin
        hole_cmd.step  = (r_state == ST_STEP) && !r_used;
        hole_cmd.shift = out_fire && dump_hole;
        hole_cmd.size  = r_size;
    end

    for (genvar g = 0; g < TOP_HOLES; g++) begin : g_hole
        logic              prev_gt;
        logic [SIZE_W-1:0] prev_size;
        logic [SIZE_W-1:0] next_size;

        if (g == 0) begin : g_first
            assign prev_gt   = 1'b0;
            assign prev_size = '0;
        end else begin : g_rest
            assign prev_gt   = hole_gt[g-1];
            assign prev_size = hole_size[g-1];
        end

        if (g == TOP_HOLES - 1) begin : g_last
            assign next_size = '0;
        end else begin : g_inner
            assign next_size = hole_size[g+1];
        end

        hbc_hole_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (hole_cmd),
            .i_prev_gt   (prev_gt),
            .i_prev_size (prev_size),
            .i_next_size (next_size),
            .o_gt        (hole_gt[g]),
            .o_size      (hole_size[g])
        );
    end

    // ------------------------------------------------------------------
    // Summary of small and unplaced used blocks, both saturating.
    // ------------------------------------------------------------------
    assign bytes_sum = {1'b0, r_other_bytes} + {1'b0, r_size};

    always_comb begin
        n_other_count = r_other_count;
        n_other_bytes = r_other_bytes;
        priority if (out_fire && dump_other) begin
            n_other_count = '0;
            n_other_bytes = '0;
        end else if ((r_state == ST_STEP) && r_used && to_other) begin
            n_other_count = (r_other_count == SIZE_MAX) ? SIZE_MAX
                                                        : r_other_count + SIZE_W'(1);
            n_other_bytes = bytes_sum[SIZE_W] ? SIZE_MAX : bytes_sum[SIZE_W-1:0];
        end else begin
            n_other_count = r_other_count;
            n_other_bytes = r_other_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_other_count <= '0;
            r_other_bytes <= '0;
        end else begin
            r_other_count <= n_other_count;
            r_other_bytes <= n_other_bytes;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_idx   = '0;
                n_state = r_end ? ST_DUMP : ST_IDLE;
            end
            ST_DUMP: begin
                if (out_fire) begin
                    if (r_idx == IDX_W'(CENSUS_LEN - 1)) begin
                        n_idx   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // ------------------------------------------------------------------
    // Result item: slot and hole items are always taken from the first cell of
    // the chain being unloaded, so the item stays put while the consumer stalls.
    // ------------------------------------------------------------------
    always_comb begin
        if (dump_slot) begin
            o_result_kind = KIND_SLOT;
            o_slot_index  = SLOT_IDX_W'(r_idx);
            o_size_value  = slot_size[0];
            o_count_value = slot_count[0];
        end else if (dump_other) begin
            o_result_kind = KIND_OTHER;
            o_slot_index  = '0;
            o_size_value  = r_other_bytes;
            o_count_value = r_other_count;
        end else begin
            o_result_kind = KIND_HOLE;
            o_slot_index  = SLOT_IDX_W'(hole_rank);
            o_size_value  = hole_size[0];
            o_count_value = '0;
        end
    end

    assign o_last_result = (r_idx == IDX_W'(CENSUS_LEN - 1));

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Occupied slots always form a contiguous run starting at slot 0.
    a_slot_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((slot_valid + SIZE_SLOTS'(1)) & slot_valid) == '0)
        else $error("size slots are not filled as a prefix");

    // An item that closes a walk starts the dump in the next cycle.
    a_dump_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP && r_end) |=> (o_out_valid && r_idx == '0))
        else $error("census dump did not start after the last block");

    // Once the final item has gone, the census is empty and input is open.
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_last_result) |=>
            (o_in_ready && slot_count[0] == '0 && hole_size[0] == '0
             && r_other_count == '0 && r_other_bytes == '0))
        else $error("census not cleared after the dump");

    // The first hole rank is never smaller than the second.
    a_hole_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (TOP_HOLES < 2) || (hole_size[0] >= hole_size[TOP_HOLES > 1 ? 1 : 0]))
        else $error("hole list out of order");

endmodule

// ===== verif/tb_heap_block_census.sv =====
// ----------------------------------------------------------------------------
// Heap block census testbench
// Feeds heap block descriptors through a bursty valid/ready driver and checks
// every census item against a cycle-free predictor kept in the testbench.
// ----------------------------------------------------------------------------
//
// The run opens with a short directed set of walks at the reset threshold.
// These cover the threshold boundary, the small-block bucket, zero-size and
// equal-size holes, and a table that overflows into the other bucket. Four
// random phases follow. Each one writes a new threshold while the block is
// idle: zero, all ones, a random value and a small random value. The sender
// works in bursts with random gaps, and the receiver stalls on a rotating
// pattern that is replaced now and then, sometimes by one with no stalls.
// ----------------------------------------------------------------------------
module tb_heap_block_census;

    import hbc_pkg::*;

    localparam int ITEMS_PER_PHASE = 112;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_PRINTED     = 40;

    // One descriptor of the heap walk, as it is put on the input channel.
    typedef struct {
        logic [SIZE_W-1:0] size;
        logic              used;
        logic              last;
    } t_heap_blk;

    // One census item that the block is expected to produce.
    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]     size;
        logic [SIZE_W-1:0]     count;
        logic                  last;
    } t_census_entry;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [SIZE_W-1:0]     i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic [SIZE_W-1:0]     i_block_size = '0;
    logic                  i_block_used = 1'b0;
    logic                  i_walk_end   = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic [KIND_W-1:0]     o_result_kind;
    logic [SLOT_IDX_W-1:0] o_slot_index;
    logic [SIZE_W-1:0]     o_size_value;
    logic [SIZE_W-1:0]     o_count_value;
    logic                  o_last_result;

    heap_block_census DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_block_size  (i_block_size),
        .i_block_used  (i_block_used),
        .i_walk_end    (i_walk_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_slot_index  (o_slot_index),
        .o_size_value  (o_size_value),
        .o_count_value (o_count_value),
        .o_last_result (o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Census predictor. It keeps its own copy of the threshold and of the
    // census, and is stepped once for every descriptor that the block takes.
    // ------------------------------------------------------------------------
    logic [SIZE_W-1:0] thresh_m = THRESHOLD_RESET;
    logic [SIZE_W-1:0] slot_size_m [SIZE_SLOTS];
    logic [SIZE_W-1:0] slot_tally  [SIZE_SLOTS];
    logic [SIZE_W-1:0] other_n;
    logic [SIZE_W-1:0] other_sum;
    logic [SIZE_W-1:0] hole_rank   [TOP_HOLES];

    t_heap_blk     blk_pending [$];
    t_census_entry census_due  [$];

    int fail_cnt  = 0;
    int res_seen  = 0;
    int cycle_cnt = 0;

    function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_W] ? SIZE_MAX : s[SIZE_W-1:0];
    endfunction

    task automatic clear_census();
        for (int i = 0; i < SIZE_SLOTS; i++) begin
            slot_size_m[i] = '0;
            slot_tally[i]  = '0;
        end
        for (int i = 0; i < TOP_HOLES; i++) begin
            hole_rank[i] = '0;
        end
        other_n   = '0;
        other_sum = '0;
    endtask

    task automatic push_entry(input logic [KIND_W-1:0] kind, input int idx,
                              input logic [SIZE_W-1:0] size,
                              input logic [SIZE_W-1:0] count, input logic last);
        t_census_entry e;
        e.kind  = kind;
        e.idx   = SLOT_IDX_W'(idx);
        e.size  = size;
        e.count = count;
        e.last  = last;
        census_due.push_back(e);
    endtask

    task automatic census_step(input t_heap_blk b);
        logic placed;
        placed = 1'b0;
        if (b.used) begin
            // A used block at or above the threshold joins the slot holding
            // its size, or claims the first empty slot; an empty slot is one
            // whose count is zero.
            if (b.size >= thresh_m) begin
                for (int i = 0; i < SIZE_SLOTS && !placed; i++) begin
                    if (slot_tally[i] == '0) begin
                        slot_size_m[i] = b.size;
                        slot_tally[i]  = SIZE_W'(1);
                        placed = 1'b1;
                    end else if (slot_size_m[i] == b.size) begin
                        slot_tally[i] = sat_add(slot_tally[i], SIZE_W'(1));
                        placed = 1'b1;
                    end
                end
            end
            if (!placed) begin
                other_n   = sat_add(other_n, SIZE_W'(1));
                other_sum = sat_add(other_sum, b.size);
            end
        end else begin
            // A hole enters the ranking only where it is strictly larger, so
            // an equal hole sinks below and a zero-size hole never enters.
            for (int i = 0; i < TOP_HOLES && !placed; i++) begin
                if (b.size > hole_rank[i]) begin
                    for (int j = TOP_HOLES - 1; j > i; j--) begin
                        hole_rank[j] = hole_rank[j-1];
                    end
                    hole_rank[i] = b.size;
                    placed = 1'b1;
                end
            end
        end
        if (b.last) begin
            for (int i = 0; i < SIZE_SLOTS; i++) begin
                push_entry(KIND_SLOT, i, slot_size_m[i], slot_tally[i], 1'b0);
            end
            push_entry(KIND_OTHER, 0, other_sum, other_n, 1'b0);
            for (int i = 0; i < TOP_HOLES; i++) begin
                push_entry(KIND_HOLE, i, hole_rank[i], '0, i == TOP_HOLES - 1);
            end
            clear_census();
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_cnt < MAX_PRINTED) begin
            $display("MISMATCH at %0t, result item %0d: %s", $time, res_seen, msg);
        end
        fail_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Input side. The handshake is sampled at the rising edge, where the
    // predictor is stepped; the driver works at the falling edge and moves
    // on to the next item once the current one has been taken.
    // ------------------------------------------------------------------------
    logic in_took    = 1'b0;
    int   gap_left   = 0;
    int   burst_left = 1;

    always @(posedge i_clk) begin
        in_took <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            census_step('{i_block_size, i_block_used, i_walk_end});
        end
    end

    always @(negedge i_clk) begin : drive_blocks
        t_heap_blk nxt;
        logic      go;
        if (i_rst_n && (!i_in_valid || in_took)) begin
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (blk_pending.size() > 0) begin
                nxt = blk_pending.pop_front();
                go  = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // A quarter of the bursts run straight into the next one.
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = $urandom_range(1, 24);
                end
            end
            i_in_valid <= go;
            if (go) begin
                i_block_size <= nxt.size;
                i_block_used <= nxt.used;
                i_walk_end   <= nxt.last;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side. Ready follows a rotating 16-bit pattern that is periodically
    // replaced by a new random one; one pattern in four has no stalls at all.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pat = 16'hffff;
    int          stall_ph  = 0;

    always @(negedge i_clk) begin
        stall_ph++;
        if (stall_ph % 128 == 0) begin
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
        end
        i_out_ready <= stall_pat[stall_ph % 16];
    end

    always @(posedge i_clk) begin : check_census
        t_census_entry want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (census_due.size() == 0) begin
                report_mismatch($sformatf("unexpected item, kind %0d index %0d",
                                          o_result_kind, o_slot_index));
            end else begin
                want = census_due.pop_front();
                if (o_result_kind !== want.kind)
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              o_result_kind, want.kind));
                if (o_slot_index !== want.idx)
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              o_slot_index, want.idx));
                if (o_size_value !== want.size)
                    report_mismatch($sformatf("size_value %h, expected %h",
                                              o_size_value, want.size));
                if (o_count_value !== want.count)
                    report_mismatch($sformatf("count_value %h, expected %h",
                                              o_count_value, want.count));
                if (o_last_result !== want.last)
                    report_mismatch($sformatf("last_result %0b, expected %0b",
                                              o_last_result, want.last));
            end
            res_seen++;
        end
    end

    // A hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    task automatic queue_block(input logic [SIZE_W-1:0] size, input logic used,
                               input logic last);
        blk_pending.push_back('{size, used, last});
    endtask

    // Sizes that one walk keeps returning to, so that slots repeat and holes
    // tie; some sit just around the current threshold.
    function automatic logic [SIZE_W-1:0] pick_pool_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return thresh_m + $urandom_range(0, 255);
            2:       return $urandom_range(0, 4095);
            default: return thresh_m - $urandom_range(1, 64);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] pool [$]);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return SIZE_W'(1);
                    2:       return SIZE_MAX;
                    default: return SIZE_MAX - $urandom_range(0, 3);
                endcase
            end
            2: return thresh_m + $urandom_range(0, 2) - 1;
            3: return $urandom_range(0, 1023);
            default: return pool[$urandom_range(0, pool.size() - 1)];
        endcase
    endfunction

    // Whole walks of random length; some use more distinct sizes than there
    // are slots, so that the table fills and spills into the other bucket.
    task automatic queue_random_walks(input int n_items);
        logic [SIZE_W-1:0] pool [$];
        int                npool;
        int                wlen;
        while (n_items > 0) begin
            pool.delete();
            npool = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 24)
                                                : $urandom_range(1, 10);
            repeat (npool) pool.push_back(pick_pool_value());
            wlen = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48)
                                               : $urandom_range(1, 20);
            if (wlen > n_items) wlen = n_items;
            for (int k = 0; k < wlen; k++) begin
                queue_block(pick_size(pool), $urandom_range(0, 99) < 55, k == wlen - 1);
            end
            n_items -= wlen;
        end
    endtask

    // Waits until every item has been taken and every census item has come
    // back, then gives an item still in its compare cycle time to finish.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (blk_pending.size() != 0 || i_in_valid || census_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_threshold(input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        thresh_m = value;
    endtask

    initial begin
        clear_census();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk one, at the reset threshold: the boundary size lands in a slot
        // and one below it goes to the other bucket, a repeat size bumps its
        // slot, and the holes see a zero size, a tie and the largest size.
        queue_block(THRESHOLD_RESET, 1'b1, 1'b0);
        queue_block(THRESHOLD_RESET - 1, 1'b1, 1'b0);
        queue_block(THRESHOLD_RESET, 1'b1, 1'b0);
        queue_block('0, 1'b1, 1'b0);
        queue_block(SIZE_MAX, 1'b1, 1'b0);
        queue_block('0, 1'b0, 1'b0);
        queue_block(SIZE_W'(100), 1'b0, 1'b0);
        queue_block(SIZE_W'(100), 1'b0, 1'b0);
        queue_block(SIZE_MAX, 1'b0, 1'b1);
        // Walk two: one distinct size more than there are slots, so the last
        // one finds the table full.
        for (int i = 0; i <= SIZE_SLOTS; i++) begin
            queue_block(SIZE_W'(4096 * (i + 1)), 1'b1, i == SIZE_SLOTS);
        end
        wait_idle();

        set_threshold('0);
        queue_random_walks(ITEMS_PER_PHASE);
        wait_idle();

        // With the threshold at its top almost every used block is small, so
        // the other byte total soon saturates.
        set_threshold(SIZE_MAX);
        queue_random_walks(ITEMS_PER_PHASE);
        wait_idle();

        set_threshold($urandom);
        queue_random_walks(ITEMS_PER_PHASE);
        wait_idle();

        set_threshold($urandom_range(0, 4096));
        queue_random_walks(ITEMS_PER_PHASE);
        wait_idle();

        if (census_due.size() != 0) begin
            report_mismatch($sformatf("%0d census items never arrived", census_due.size()));
        end
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
